### hdl/mdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdf_pkg
// Types, constants and the control store of the median dead-band filter.
// ----------------------------------------------------------------------------
package mdf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 2;
  localparam int STEP_W   = 3;

  localparam logic [SAMPLE_W-1:0] DEADBAND_RESET = 12'd4;

  typedef logic [STEP_W-1:0] step_t;

  // Program step labels
  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_WRITE  = 3'd1;
  localparam step_t ST_READ   = 3'd2;
  localparam step_t ST_DRAIN  = 3'd3;
  localparam step_t ST_SELECT = 3'd4;
  localparam step_t ST_EMIT   = 3'd5;
  localparam step_t ST_LAST   = ST_EMIT;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_WRITE,
    OP_READ,
    OP_DRAIN,
    OP_SELECT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_BAD_CHAN,
    C_MORE_READS,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_input;
    logic bad_chan;
    logic more_reads;
    logic out_busy;
  } cond_flags_t;

  // Control store: taken jump goes to target, otherwise fall through
  function automatic ctrl_word_t prog_rom(input step_t s);
    ctrl_word_t w;
    unique case (s)
      ST_IDLE:   w = '{op: OP_IDLE,   cond: C_NO_INPUT,   target: ST_IDLE};
      ST_WRITE:  w = '{op: OP_WRITE,  cond: C_BAD_CHAN,   target: ST_EMIT};
      ST_READ:   w = '{op: OP_READ,   cond: C_MORE_READS, target: ST_READ};
      ST_DRAIN:  w = '{op: OP_DRAIN,  cond: C_NEVER,      target: ST_IDLE};
      ST_SELECT: w = '{op: OP_SELECT, cond: C_NEVER,      target: ST_IDLE};
      ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,   target: ST_EMIT};
      default:   w = '{op: OP_DRAIN,  cond: C_ALWAYS,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/mdf_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdf_sequencer
// Step counter over the control store, with conditional jumps on datapath
// flags. Presents the control word of the current step.
// ----------------------------------------------------------------------------
module mdf_sequencer
  import mdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cond_flags_t flags,
  output ctrl_word_t  ctrl
);

  step_t step;
  step_t step_next;
  logic  taken;

  assign ctrl = prog_rom(step);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_INPUT:   taken = flags.no_input;
      C_BAD_CHAN:   taken = flags.bad_chan;
      C_MORE_READS: taken = flags.more_reads;
      C_OUT_BUSY:   taken = flags.out_busy;
      default:      taken = 1'b1;
    endcase
    if (taken) begin
      step_next = ctrl.target;
    end else if (step == ST_LAST) begin
      step_next = ST_IDLE;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

### hdl/median_deadband_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_deadband_filter
// Per-channel sliding median of ADC samples followed by a dead band.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfer (in_valid, in_stall, channel, sample) carries one sample.
//   It is written over the oldest entry of that channel's ring, the ring is
//   ranked and the entry at sorted position WINDOW/2 is taken. A change from
//   the channel's held output that is nonzero and below deadband_limit is
//   suppressed and the held output repeated. Channels at or above CHANNELS
//   return 0 and leave all state alone.
//   Output transfer (out_valid, out_stall, channel_out, filtered) gives one
//   result per sample, in order.
//   cfg_valid/cfg_ready/cfg_data writes deadband_limit (reset value 4).
// Timing: the ring is read one entry per cycle through the single memory
//   read port while each entry is ranked against those already read.
// Reset: rings, write positions and held outputs read as zero at once; the
//   ring memory carries one valid flag per entry, so no clearing pass.
// Stall: a result held by out_stall stays in the output register; the
//   next sample is taken meanwhile and waits at its last step.
// ----------------------------------------------------------------------------
module median_deadband_filter
  import mdf_pkg::*;
#(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAN_W-1:0]   channel_out,
  output logic [SAMPLE_W-1:0] filtered,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LC_W   = $clog2(WINDOW + 1);
  localparam int MID    = WINDOW / 2;

  ctrl_word_t  ctrl;
  cond_flags_t flags;

  // Latched item
  logic [CHAN_W-1:0]   chan_reg;
  logic [SAMPLE_W-1:0] sample_reg;
  logic                bad;
  logic [ADDR_W-1:0]   base;

  // Per-channel state
  logic [POS_W-1:0]    wr_pos [CHANNELS];
  logic [SAMPLE_W-1:0] held   [CHANNELS];
  logic [SAMPLE_W-1:0] deadband_limit;

  // Ring memory
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    entry_ok;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_ok;
  logic                rd_pend;
  logic [POS_W-1:0]    rd_idx;

  // Ranking lanes
  logic [SAMPLE_W-1:0] lane_val  [WINDOW];
  logic [POS_W-1:0]    lane_rank [WINDOW];
  logic [LC_W-1:0]     lane_cnt;
  logic [SAMPLE_W-1:0] med;

  logic [CIW-1:0]      ch_idx;
  logic [POS_W-1:0]    pos_cur;
  logic [POS_W-1:0]    pos_next;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_val;
  logic [POS_W-1:0]    new_rank;
  logic [SAMPLE_W-1:0] med_sel;
  logic [SAMPLE_W-1:0] last;
  logic [SAMPLE_W-1:0] diff;
  logic                hold;
  logic [SAMPLE_W-1:0] result;
  logic                out_free;
  logic                in_take;
  logic                bad_in;

  mdf_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_stall  = (ctrl.op != OP_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign bad_in    = (5'(channel) >= 5'(CHANNELS));

  assign flags.no_input   = !in_valid;
  assign flags.bad_chan   = bad;
  assign flags.more_reads = (rd_idx != POS_W'(WINDOW - 1));
  assign flags.out_busy   = !out_free;

  assign ch_idx   = CIW'(chan_reg);
  assign pos_cur  = wr_pos[ch_idx];
  assign pos_next = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + POS_W'(1);
  assign wr_addr  = base + ADDR_W'(pos_cur);
  assign rd_addr  = base + ADDR_W'(rd_idx);
  assign rd_val   = rd_ok ? rd_data : '0;

  // Rank of the arriving entry: earlier lanes at or below it
  always_comb begin
    new_rank = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if ((LC_W'(i) < lane_cnt) && (lane_val[i] <= rd_val)) begin
        new_rank = new_rank + POS_W'(1);
      end
    end
  end

  always_comb begin
    med_sel = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (lane_rank[i] == POS_W'(MID)) begin
        med_sel = med_sel | lane_val[i];
      end
    end
  end

  assign last   = held[ch_idx];
  assign diff   = (med > last) ? (med - last) : (last - med);
  assign hold   = (diff != '0) && (diff < deadband_limit);
  assign result = bad ? '0 : (hold ? last : med);

  // Ring memory: write the new sample first, then stream the ring out
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_WRITE && !bad) begin
      mem[wr_addr] <= sample_reg;
    end
    rd_data <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      rd_pend        <= 1'b0;
      lane_cnt       <= '0;
      entry_ok       <= '0;
      deadband_limit <= DEADBAND_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        wr_pos[c] <= '0;
        held[c]   <= '0;
      end
    end else begin
      if (cfg_valid) begin
        deadband_limit <= cfg_data;
      end
      rd_pend <= (ctrl.op == OP_READ);
      if (ctrl.op == OP_WRITE) begin
        lane_cnt <= '0;
        if (!bad) begin
          entry_ok[wr_addr] <= 1'b1;
          wr_pos[ch_idx]    <= pos_next;
        end
      end else if (rd_pend) begin
        lane_cnt <= lane_cnt + LC_W'(1);
      end
      if (ctrl.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
        if (!bad && !hold) begin
          held[ch_idx] <= med;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      chan_reg   <= channel;
      sample_reg <= sample;
      bad        <= bad_in;
      base       <= ADDR_W'(CIW'(channel) * WINDOW);
    end
    if (ctrl.op == OP_WRITE) begin
      rd_idx <= '0;
    end else if (ctrl.op == OP_READ) begin
      rd_idx <= rd_idx + POS_W'(1);
      rd_ok  <= entry_ok[rd_addr];
    end
    // Rank the arriving entry against those already held
    if (rd_pend) begin
      for (int i = 0; i < WINDOW; i++) begin
        if ((LC_W'(i) < lane_cnt) && (lane_val[i] > rd_val)) begin
          lane_rank[i] <= lane_rank[i] + POS_W'(1);
        end
        if (LC_W'(i) == lane_cnt) begin
          lane_val[i]  <= rd_val;
          lane_rank[i] <= new_rank;
        end
      end
    end
    if (ctrl.op == OP_SELECT) begin
      med <= med_sel;
    end
    if (ctrl.op == OP_EMIT && out_free) begin
      channel_out <= chan_reg;
      filtered    <= result;
    end
  end

endmodule

### hdl/mdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdf_checker
// Port-level checks for the median dead-band filter, bound to the top level.
// ----------------------------------------------------------------------------
module mdf_checker
  import mdf_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic [CHAN_W-1:0]   channel,
  input logic [SAMPLE_W-1:0] sample,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CHAN_W-1:0]   channel_out,
  input logic [SAMPLE_W-1:0] filtered
);

  // Stalled input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(channel) && $stable(sample))
    else $error("input changed under stall");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(channel_out) && $stable(filtered))
    else $error("result changed under stall");

  // One sample in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while a sample is in work");

  // Unused channels return zero
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (5'(channel_out) >= 5'(CHANNELS)) |-> filtered == '0)
    else $error("nonzero result on an unused channel");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind median_deadband_filter mdf_checker #(.CHANNELS(CHANNELS)) u_mdf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .channel     (channel),
  .sample      (sample),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .channel_out (channel_out),
  .filtered    (filtered)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the median dead-band filter.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of every channel's sample ring, write
// position and held output, and of the dead-band limit. It works out the
// filtered value for each sample the block accepts and compares it with the
// block's results in order. Stimulus is a short directed set followed by
// random phases, each under its own limit. The phases use per-channel random
// walks, full-range samples and extremes. The sender works in bursts and the
// receiver stalls on its own pattern, with long hold-offs now and then.
// ----------------------------------------------------------------------------
module testbench
  import mdf_pkg::*;
();

  localparam int NUM_CH          = 4;
  localparam int WIN             = 5;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] value;
  } filt_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample;
  logic                out_valid;
  logic                out_stall;
  logic [CHAN_W-1:0]   channel_out;
  logic [SAMPLE_W-1:0] filtered;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SAMPLE_W-1:0] cfg_data;

  median_deadband_filter #(
    .CHANNELS(NUM_CH),
    .WINDOW  (WIN)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .channel    (channel),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel_out(channel_out),
    .filtered   (filtered),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  class median_scoreboard;
    logic [SAMPLE_W-1:0] ring [NUM_CH][WIN];
    int unsigned         wr_pos [NUM_CH];
    logic [SAMPLE_W-1:0] held [NUM_CH];
    logic [SAMPLE_W-1:0] deadband;
    filt_result_t        awaited_q[$];
    int unsigned         errors;

    function new();
      foreach (ring[c, k]) ring[c][k] = '0;
      foreach (wr_pos[c]) wr_pos[c] = 0;
      foreach (held[c]) held[c] = '0;
      deadband = DEADBAND_RESET;
      errors   = 0;
    endfunction

    // Pick the entry whose rank straddles the middle position
    function logic [SAMPLE_W-1:0] ranked_median(int unsigned ch);
      int below;
      int at_or_below;
      for (int i = 0; i < WIN; i++) begin
        below       = 0;
        at_or_below = 0;
        for (int j = 0; j < WIN; j++) begin
          if (ring[ch][j] < ring[ch][i]) below++;
          if (ring[ch][j] <= ring[ch][i]) at_or_below++;
        end
        if (below <= WIN / 2 && at_or_below > WIN / 2) return ring[ch][i];
      end
      return '0;
    endfunction

    function void note_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] s);
      filt_result_t        r;
      logic [SAMPLE_W-1:0] med;
      logic [SAMPLE_W-1:0] diff;
      r.chan = ch;
      if (int'(ch) >= NUM_CH) begin
        r.value = '0;
        awaited_q.push_back(r);
        return;
      end
      ring[ch][wr_pos[ch]] = s;
      wr_pos[ch] = (wr_pos[ch] + 1 == WIN) ? 0 : wr_pos[ch] + 1;
      med  = ranked_median(ch);
      diff = (med > held[ch]) ? med - held[ch] : held[ch] - med;
      if (diff != 0 && diff < deadband) begin
        r.value = held[ch];
      end else begin
        held[ch] = med;
        r.value  = med;
      end
      awaited_q.push_back(r);
    endfunction

    function void check_result(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] val);
      filt_result_t exp_r;
      if (awaited_q.size() == 0) begin
        $error("unexpected result: channel_out %0d filtered %0d", ch, val);
        errors++;
        return;
      end
      exp_r = awaited_q.pop_front();
      if (ch !== exp_r.chan) begin
        $error("channel_out mismatch: expected %0d, actual %0d", exp_r.chan, ch);
        errors++;
      end
      if (val !== exp_r.value) begin
        $error("filtered mismatch: expected %0d, actual %0d", exp_r.value, val);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  median_scoreboard sb;
  int               burst_left;
  int               walk_level [NUM_CH];
  int               hold_off_requests;
  int               hold_off_served;
  int               stuck_cycles;

  // Receiver side: check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(channel_out, filtered);
  end

  // Watchdog: cycles with no transfer on any interface
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("median_deadband_filter verification failed");
      $finish;
    end
  end

  // Receiver stall pattern, with long hold-offs on request
  initial begin
    int          seg_left;
    int          hold_left;
    stall_mode_t mode;
    seg_left        = 0;
    hold_left       = 0;
    mode            = STALL_NONE;
    hold_off_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_served != hold_off_requests) begin
        hold_off_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (seg_left == 0) begin
        mode     = stall_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(ch, s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(0, 12);
    end
  endtask

  // Hold the sender until every result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (WIN + 6) @(posedge clk);
  endtask

  task automatic write_deadband(input logic [SAMPLE_W-1:0] limit);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.deadband = limit;
  endtask

  // Mostly walk near the level, with jumps, extremes and repeats
  function automatic logic [SAMPLE_W-1:0] pick_sample(int ch);
    int roll;
    int span;
    int level;
    roll = $urandom_range(0, 99);
    span = int'(sb.deadband) + 4;
    if (span > 400) span = 400;
    if (roll < 55) begin
      level = walk_level[ch] + int'($urandom_range(0, 2 * span)) - span;
      if (level < 0) level = 0;
      if (level > 4095) level = 4095;
      walk_level[ch] = level;
    end else if (roll < 72) begin
      level = $urandom_range(0, 4095);
    end else if (roll < 82) begin
      case ($urandom_range(0, 3))
        0:       level = 0;
        1:       level = 4095;
        2:       level = 1;
        default: level = 4094;
      endcase
    end else begin
      level = walk_level[ch];
    end
    return level[SAMPLE_W-1:0];
  endfunction

  task automatic run_phase(input logic [SAMPLE_W-1:0] limit, input int count,
                           input bit with_hold_off);
    int ch;
    write_deadband(limit);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_results();
      if (with_hold_off && n == count / 3) hold_off_requests++;
      ch = $urandom_range(0, NUM_CH - 1);
      send_sample(ch[CHAN_W-1:0], pick_sample(ch));
    end
  endtask

  initial begin
    int dir_ch [22] = '{0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1,
                        2, 2, 2, 2, 3, 3, 3, 3, 3, 2, 3};
    int dir_s  [22] = '{4095, 4095, 4095, 4093, 0, 3, 3, 3, 4, 4, 7,
                        2730, 1365, 2730, 2730, 4095, 0, 2048, 1, 4094, 1365, 4095};
    sb                = new();
    burst_left        = 0;
    hold_off_requests = 0;
    stuck_cycles      = 0;
    foreach (walk_level[c]) walk_level[c] = $urandom_range(0, 4095);
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    channel   <= '0;
    sample    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Initial rings, extremes, dead-band hold, equal median, limit boundary
    for (int n = 0; n < 22; n++) send_sample(dir_ch[n][CHAN_W-1:0], dir_s[n][SAMPLE_W-1:0]);
    // Zero limit: single-step changes must pass
    write_deadband('0);
    for (int n = 0; n < 3; n++) send_sample(CHAN_W'(1), SAMPLE_W'(5 + n));

    run_phase(12'd4095, 160, 1'b0);
    run_phase(12'd1, 160, 1'b1);
    run_phase(12'd0, 160, 1'b0);
    run_phase(SAMPLE_W'($urandom_range(2, 64)), 160, 1'b1);
    run_phase(12'd16, 160, 1'b0);
    run_phase(12'd4, 160, 1'b1);
    run_phase(SAMPLE_W'($urandom_range(0, 4095)), 120, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (WIN + 10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("median_deadband_filter verification clean");
    end else begin
      $display("median_deadband_filter verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mdf_pkg.sv
hdl/mdf_sequencer.sv
hdl/median_deadband_filter.sv
hdl/mdf_checker.sv
verif/testbench.sv
